/* src/ibeacon_adv_parser_dedup_assert.svh */
// Assertion macros shared by the checker files.
`ifndef IBEACON_ADV_PARSER_DEDUP_ASSERT_SVH
`define IBEACON_ADV_PARSER_DEDUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define IBCN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define IBCN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ibcn_pkg.sv */
// Package: item types and status codes of the iBeacon advertisement parser.
package ibcn_pkg;

	typedef enum logic [2:0] {
		ST_NOT_BEACON = 3'd0,
		ST_FILTERED   = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_STORED_NEW = 3'd3,
		ST_SCAN_DONE  = 3'd4
	} status_t;

	typedef enum logic {
		OP_ADV_BYTE  = 1'b0,
		OP_SCAN_DONE = 1'b1
	} op_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] adv_byte;
		logic       last_byte;
	} adv_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  colour;
		logic [15:0] temperature;
		logic [15:0] gravity;
		logic [3:0]  stored_count;
	} res_item_t;

	localparam logic [3:0] COLOUR_MIN = 4'd1;
	localparam logic [3:0] COLOUR_MAX = 4'd8;
	localparam logic [3:0] COUNT_MAX  = 4'd8;

endpackage

/* src/ibeacon_adv_parser_dedup.sv */
// Top level: iBeacon advertisement parser with per-scan colour dedup.
// Takes one advertising payload byte (or a scan-complete item) per cycle and
// sustains one item per cycle while no result is held by res_stall. Each
// item passes an input register, and the parser state is updated as it
// leaves that register, as its result (if any) is written to the output
// register. Only the last byte of an advertisement and scan-complete items
// give a result; other bytes never wait on res_stall.
// colour_filter sits at byte address 0 of the APB port and is to be written
// only while no item is in flight; the user must ensure this, the block does not.
module ibeacon_adv_parser_dedup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 adv_valid,
	output logic                 adv_stall,
	input  ibcn_pkg::adv_item_t  adv_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output ibcn_pkg::res_item_t  res_item
);

	logic                 valid_s1;
	ibcn_pkg::adv_item_t  item_s1;
	logic                 res_valid_q;
	ibcn_pkg::res_item_t  res_q;
	ibcn_pkg::res_item_t  result;
	logic [3:0]           colour_filter_q;
	logic                 has_result;
	logic                 out_free;
	logic                 go;
	logic                 reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == 1'b0);
	assign prdata  = reg_sel ? {28'd0, colour_filter_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_filter_q <= 4'd0;
		end else if (psel && penable && pwrite && reg_sel) begin
			colour_filter_q <= pwdata[3:0];
		end
	end

	assign has_result = (item_s1.operation == ibcn_pkg::OP_SCAN_DONE) || item_s1.last_byte;
	assign out_free   = !res_valid_q || !res_stall;
	assign go         = valid_s1 && (!has_result || out_free);
	assign adv_stall  = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || go) begin
			valid_s1 <= adv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_valid && !adv_stall)
			item_s1 <= adv_item;
	end

	ibcn_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (go),
		.item          (item_s1),
		.colour_filter (colour_filter_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && has_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result)
			res_q <= result;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

/* src/ibcn_core.sv */
// Parser state and per-byte next-state logic: structure walk, match, colour record, dedup, result.
module ibcn_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ibcn_pkg::adv_item_t   item,
	input  logic [3:0]            colour_filter,
	output ibcn_pkg::res_item_t   result
);

	localparam logic [7:0] MIN_BEACON_LEN = 8'd26;
	localparam logic [4:0] OFFSET_MAX     = 5'd31;
	localparam logic [4:0] OFF_COLOUR     = 5'd8;
	localparam logic [4:0] OFF_TEMP_HI    = 5'd21;
	localparam logic [4:0] OFF_TEMP_LO    = 5'd22;
	localparam logic [4:0] OFF_GRAV_HI    = 5'd23;
	localparam logic [4:0] OFF_GRAV_LO    = 5'd24;

	typedef enum logic [1:0] {
		V_UNDECIDED  = 2'd0,
		V_NOT_BEACON = 2'd1,
		V_BEACON     = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       cmp;
		logic [7:0] value;
	} expect_t;

	// Fixed bytes of the manufacturer structure: header, company, type, UUID.
	function automatic expect_t expected_byte(input logic [4:0] off);
		expect_t e;
		e.cmp = 1'b1;
		unique case (off)
			5'd0:  e.value = 8'hFF;
			5'd1:  e.value = 8'h4C;
			5'd2:  e.value = 8'h00;
			5'd3:  e.value = 8'h02;
			5'd4:  e.value = 8'h15;
			5'd5:  e.value = 8'hA4;
			5'd6:  e.value = 8'h95;
			5'd7:  e.value = 8'hBB;
			5'd9:  e.value = 8'hC5;
			5'd10: e.value = 8'hB1;
			5'd11: e.value = 8'h4B;
			5'd12: e.value = 8'h44;
			5'd13: e.value = 8'hB5;
			5'd14: e.value = 8'h12;
			5'd15: e.value = 8'h13;
			5'd16: e.value = 8'h70;
			5'd17: e.value = 8'hF0;
			5'd18: e.value = 8'h2D;
			5'd19: e.value = 8'h74;
			5'd20: e.value = 8'hDE;
			default: begin
				e.cmp   = 1'b0;
				e.value = 8'h00;
			end
		endcase
		return e;
	endfunction

	logic [7:0]  left_q, left_n;
	logic [4:0]  off_q, off_n;
	logic        match_q, match_n;
	logic        stopped_q, stopped_n;
	verdict_t    verdict_q, verdict_n;
	logic [3:0]  col_q, col_n;
	logic [15:0] temp_q, temp_n;
	logic [15:0] grav_q, grav_n;
	logic [7:0]  seen_q, seen_n;
	logic [3:0]  cnt_q, cnt_n;

	expect_t     exp_b;
	logic [3:0]  col_m1;
	logic        filtered;
	logic        dup;

	assign exp_b  = expected_byte(off_q);

	always_comb begin
		left_n    = left_q;
		off_n     = off_q;
		match_n   = match_q;
		stopped_n = stopped_q;
		verdict_n = verdict_q;
		col_n     = col_q;
		temp_n    = temp_q;
		grav_n    = grav_q;
		seen_n    = seen_q;
		cnt_n     = cnt_q;
		col_m1    = 4'd0;
		filtered  = 1'b0;
		dup       = 1'b0;

		result.status       = ibcn_pkg::ST_NOT_BEACON;
		result.colour       = 4'd0;
		result.temperature  = 16'd0;
		result.gravity      = 16'd0;
		result.stored_count = cnt_q;

		if (item.operation == ibcn_pkg::OP_SCAN_DONE) begin
			result.status = ibcn_pkg::ST_SCAN_DONE;
			seen_n        = 8'd0;
			cnt_n         = 4'd0;
		end else begin
			if (!stopped_q) begin
				if (left_q == 8'd0) begin
					// length byte opens a structure; zero ends the payload
					if (item.adv_byte == 8'd0) begin
						stopped_n = 1'b1;
					end else begin
						left_n  = item.adv_byte;
						off_n   = 5'd0;
						match_n = (item.adv_byte >= MIN_BEACON_LEN);
					end
				end else begin
					left_n = left_q - 8'd1;
					if (match_q) begin
						if (exp_b.cmp && item.adv_byte != exp_b.value)
							match_n = 1'b0;
						if (off_q == OFF_COLOUR)  col_n = item.adv_byte[7:4];
						if (off_q == OFF_TEMP_HI) temp_n = {item.adv_byte, 8'd0};
						if (off_q == OFF_TEMP_LO) temp_n = {temp_q[15:8], item.adv_byte};
						if (off_q == OFF_GRAV_HI) grav_n = {item.adv_byte, 8'd0};
						if (off_q == OFF_GRAV_LO) grav_n = {grav_q[15:8], item.adv_byte};
					end
					if (off_q != OFFSET_MAX) off_n = off_q + 5'd1;
					if (left_n == 8'd0 && match_n) begin
						if (col_n >= ibcn_pkg::COLOUR_MIN && col_n <= ibcn_pkg::COLOUR_MAX)
							verdict_n = V_BEACON;
						else
							verdict_n = V_NOT_BEACON;
						stopped_n = 1'b1;
					end
				end
			end

			if (item.last_byte && verdict_n == V_BEACON) begin
				col_m1   = col_n - 4'd1;
				filtered = (colour_filter != 4'd0) && (colour_filter != col_n);
				dup      = seen_q[col_m1[2:0]];
				result.colour      = col_n;
				result.temperature = temp_n;
				result.gravity     = grav_n;
				priority if (filtered) begin
					result.status = ibcn_pkg::ST_FILTERED;
				end else if (dup) begin
					result.status = ibcn_pkg::ST_DUPLICATE;
				end else begin
					result.status = ibcn_pkg::ST_STORED_NEW;
					seen_n[col_m1[2:0]] = 1'b1;
					if (cnt_q < ibcn_pkg::COUNT_MAX) cnt_n = cnt_q + 4'd1;
				end
				result.stored_count = cnt_n;
			end
		end

		// end of advertisement or scan: drop the parse state
		if (item.operation == ibcn_pkg::OP_SCAN_DONE || item.last_byte) begin
			left_n    = 8'd0;
			off_n     = 5'd0;
			match_n   = 1'b0;
			stopped_n = 1'b0;
			verdict_n = V_UNDECIDED;
			col_n     = 4'd0;
			temp_n    = 16'd0;
			grav_n    = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= 8'd0;
			off_q     <= 5'd0;
			match_q   <= 1'b0;
			stopped_q <= 1'b0;
			verdict_q <= V_UNDECIDED;
			col_q     <= 4'd0;
			temp_q    <= 16'd0;
			grav_q    <= 16'd0;
			seen_q    <= 8'd0;
			cnt_q     <= 4'd0;
		end else if (step) begin
			left_q    <= left_n;
			off_q     <= off_n;
			match_q   <= match_n;
			stopped_q <= stopped_n;
			verdict_q <= verdict_n;
			col_q     <= col_n;
			temp_q    <= temp_n;
			grav_q    <= grav_n;
			seen_q    <= seen_n;
			cnt_q     <= cnt_n;
		end
	end

endmodule

/* src/ibcn_checker.sv */
// Port-level checker for the iBeacon parser, bound to the top level.
`include "ibeacon_adv_parser_dedup_assert.svh"

module ibcn_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  ibcn_pkg::res_item_t  res_item
);

	logic no_reading;
	logic beacon;

	assign no_reading = res_item.status == ibcn_pkg::ST_NOT_BEACON
		|| res_item.status == ibcn_pkg::ST_SCAN_DONE;
	assign beacon = res_item.status == ibcn_pkg::ST_FILTERED
		|| res_item.status == ibcn_pkg::ST_DUPLICATE
		|| res_item.status == ibcn_pkg::ST_STORED_NEW;

	// a stalled result item stays put
	`IBCN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item), "result item changed while stalled")

	`IBCN_ASSERT_NOW(a_status_known, res_valid, no_reading || beacon, "status code out of range")

	`IBCN_ASSERT_NOW(a_no_reading_zero, res_valid && no_reading, res_item.colour == 4'd0 && res_item.temperature == 16'd0 && res_item.gravity == 16'd0, "reading fields set on a non-beacon result")

	`IBCN_ASSERT_NOW(a_beacon_colour, res_valid && beacon, res_item.colour >= ibcn_pkg::COLOUR_MIN && res_item.colour <= ibcn_pkg::COLOUR_MAX, "beacon colour out of range")

	`IBCN_ASSERT_NOW(a_count_range, res_valid, res_item.stored_count <= ibcn_pkg::COUNT_MAX && (res_item.status != ibcn_pkg::ST_STORED_NEW || res_item.stored_count != 4'd0), "stored count inconsistent")

endmodule

bind ibeacon_adv_parser_dedup ibcn_checker u_ibcn_checker (.*);

/* verif/tb_ibeacon_adv_parser_dedup.sv */
// Testbench for the iBeacon advertisement parser: random ads, scoreboard, APB filter writes.
module tb_ibeacon_adv_parser_dedup;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		VD_UNDECIDED  = 2'd0,
		VD_NOT_BEACON = 2'd1,
		VD_BEACON     = 2'd2
	} verdict_t;

	localparam logic [2:0] ADDR_COLOUR_FILTER = 3'd0;
	localparam int MIN_BEACON_LEN = 26;
	localparam int OFFSET_SAT     = 31;
	localparam int OFS_COLOUR     = 8;
	localparam int OFS_TEMP_HI    = 21;
	localparam int OFS_TEMP_LO    = 22;
	localparam int OFS_GRAV_HI    = 23;
	localparam int OFS_GRAV_LO    = 24;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [2:0]          paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                adv_valid = 1'b0;
	logic                adv_stall;
	ibcn_pkg::adv_item_t adv_item  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	ibcn_pkg::res_item_t res_item;

	ibeacon_adv_parser_dedup dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.adv_valid(adv_valid), .adv_stall(adv_stall), .adv_item(adv_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	ibcn_pkg::adv_item_t pending_items[$];
	ibcn_pkg::res_item_t expected_results[$];
	logic [7:0]  ad_bytes[$];
	int unsigned gen_items   = 0;
	int unsigned gen_results = 0;
	int unsigned errors      = 0;
	int unsigned send_idle_pct = 13;
	int unsigned recv_idle_pct = 65;
	logic        adv_took = 1'b0;

	// parser mirror
	logic [3:0]  filter_cfg = 4'd0;
	logic [7:0]  left_in_struct = '0;
	logic [4:0]  struct_ofs = '0;
	logic        still_match = 1'b0;
	logic        stopped = 1'b0;
	verdict_t    verdict = VD_UNDECIDED;
	logic [3:0]  cand_colour = '0;
	logic [15:0] cand_temp = '0;
	logic [15:0] cand_grav = '0;
	logic [7:0]  seen_colours = '0;
	logic [3:0]  n_stored = '0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Fixed bytes of the manufacturer structure: header, then UUID around the colour byte.
	function automatic logic [7:0] frame_byte(input int o);
		case (o)
			0:  return 8'hFF;
			1:  return 8'h4C;
			2:  return 8'h00;
			3:  return 8'h02;
			4:  return 8'h15;
			5:  return 8'ha4;
			6:  return 8'h95;
			7:  return 8'hbb;
			9:  return 8'hc5;
			10: return 8'hb1;
			11: return 8'h4b;
			12: return 8'h44;
			13: return 8'hb5;
			14: return 8'h12;
			15: return 8'h13;
			16: return 8'h70;
			17: return 8'hf0;
			18: return 8'h2d;
			19: return 8'h74;
			20: return 8'hde;
			default: return 8'h00;
		endcase
	endfunction

	task automatic clear_parse();
		left_in_struct = '0;
		struct_ofs = '0;
		still_match = 1'b0;
		stopped = 1'b0;
		verdict = VD_UNDECIDED;
		cand_colour = '0;
		cand_temp = '0;
		cand_grav = '0;
	endtask

	task automatic take_payload_byte(input logic [7:0] b);
		int o;
		if (left_in_struct == 0) begin
			if (b == 8'd0) begin
				stopped = 1'b1;
			end else begin
				left_in_struct = b;
				struct_ofs = '0;
				still_match = (b >= MIN_BEACON_LEN);
			end
		end else begin
			o = struct_ofs;
			left_in_struct = left_in_struct - 8'd1;
			if (still_match) begin
				if (o == OFS_COLOUR) begin
					cand_colour = b[7:4];
				end else if (o < OFS_TEMP_HI) begin
					if (b != frame_byte(o)) still_match = 1'b0;
				end else if (o == OFS_TEMP_HI) begin
					cand_temp = {b, 8'h00};
				end else if (o == OFS_TEMP_LO) begin
					cand_temp[7:0] = cand_temp[7:0] | b;
				end else if (o == OFS_GRAV_HI) begin
					cand_grav = {b, 8'h00};
				end else if (o == OFS_GRAV_LO) begin
					cand_grav[7:0] = cand_grav[7:0] | b;
				end
			end
			if (o < OFFSET_SAT) struct_ofs = 5'(o + 1);
			if (left_in_struct == 0 && still_match) begin
				if (cand_colour >= ibcn_pkg::COLOUR_MIN && cand_colour <= ibcn_pkg::COLOUR_MAX)
					verdict = VD_BEACON;
				else
					verdict = VD_NOT_BEACON;
				stopped = 1'b1;
			end
		end
	endtask

	task automatic predict_item(input ibcn_pkg::adv_item_t it);
		ibcn_pkg::res_item_t r;
		logic [7:0]          colour_bit;
		r = '0;
		if (it.operation == ibcn_pkg::OP_SCAN_DONE) begin
			r.status = ibcn_pkg::ST_SCAN_DONE;
			r.stored_count = n_stored;
			expected_results.push_back(r);
			clear_parse();
			seen_colours = '0;
			n_stored = '0;
		end else begin
			if (!stopped) take_payload_byte(it.adv_byte);
			if (it.last_byte) begin
				if (verdict == VD_BEACON) begin
					colour_bit = 8'd1 << (cand_colour - 4'd1);
					r.colour = cand_colour;
					r.temperature = cand_temp;
					r.gravity = cand_grav;
					if (filter_cfg != 4'd0 && filter_cfg != cand_colour) begin
						r.status = ibcn_pkg::ST_FILTERED;
					end else if ((seen_colours & colour_bit) != 0) begin
						r.status = ibcn_pkg::ST_DUPLICATE;
					end else begin
						seen_colours = seen_colours | colour_bit;
						if (n_stored < ibcn_pkg::COUNT_MAX) n_stored = n_stored + 4'd1;
						r.status = ibcn_pkg::ST_STORED_NEW;
					end
				end else begin
					r.status = ibcn_pkg::ST_NOT_BEACON;
				end
				r.stored_count = n_stored;
				expected_results.push_back(r);
				clear_parse();
			end
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// driver: items and receiver stall change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
			if (!adv_valid || adv_took) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					adv_item <= pending_items.pop_front();
					adv_valid <= 1'b1;
				end else begin
					adv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: accepted items feed the mirror, accepted results are checked
	always @(posedge clk) begin : mon
		ibcn_pkg::res_item_t want;
		if (!arst_n) begin
			adv_took <= 1'b0;
		end else begin
			adv_took <= adv_valid && !adv_stall;
			if (adv_valid && !adv_stall) predict_item(adv_item);
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %0h", $time, res_item);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, res_item.status);
					check_field("colour", want.colour, res_item.colour);
					check_field("temperature", want.temperature, res_item.temperature);
					check_field("gravity", want.gravity, res_item.gravity);
					check_field("stored_count", want.stored_count, res_item.stored_count);
				end
			end
		end
	end

	task automatic push_adv(input logic [7:0] b, input logic last);
		ibcn_pkg::adv_item_t it;
		it.operation = ibcn_pkg::OP_ADV_BYTE;
		it.adv_byte = b;
		it.last_byte = last;
		pending_items.push_back(it);
		gen_items++;
		if (last) gen_results++;
	endtask

	// scan complete ignores the other fields, so they get random values
	task automatic push_scan();
		ibcn_pkg::adv_item_t it;
		it.operation = ibcn_pkg::OP_SCAN_DONE;
		it.adv_byte = 8'($urandom_range(255));
		it.last_byte = 1'($urandom_range(1));
		pending_items.push_back(it);
		gen_items++;
		gen_results++;
	endtask

	// queue the collected ad; optionally a scan complete cuts into it
	task automatic send_ad(input bit split);
		int unsigned cut;
		cut = $urandom_range(ad_bytes.size() - 1);
		foreach (ad_bytes[i]) begin
			if (split && i == cut) push_scan();
			push_adv(ad_bytes[i], i == ad_bytes.size() - 1);
		end
		ad_bytes.delete();
	endtask

	task automatic add_beacon(input logic [3:0] nib, input int len, input logic [15:0] temp,
			input logic [15:0] grav, input int corrupt);
		logic [7:0] b;
		ad_bytes.push_back(8'(len));
		for (int o = 0; o < len; o++) begin
			if (o == OFS_COLOUR) b = {nib, 4'($urandom_range(15))};
			else if (o < OFS_TEMP_HI) b = frame_byte(o);
			else if (o == OFS_TEMP_HI) b = temp[15:8];
			else if (o == OFS_TEMP_LO) b = temp[7:0];
			else if (o == OFS_GRAV_HI) b = grav[15:8];
			else if (o == OFS_GRAV_LO) b = grav[7:0];
			else b = 8'($urandom_range(255));
			if (o == corrupt) b = b ^ 8'($urandom_range(1, 255));
			ad_bytes.push_back(b);
		end
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic add_filler();
		int unsigned len;
		len = $urandom_range(1, 10);
		ad_bytes.push_back(8'(len));
		repeat (len) ad_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic add_random_beacon();
		int unsigned k;
		int len, corrupt;
		logic [3:0] nib;
		k = $urandom_range(7);
		if ($urandom_range(9) != 0) nib = 4'($urandom_range(1, 8));
		else nib = (k == 0) ? 4'd0 : 4'(k + 8);
		case ($urandom_range(19))
			0: len = $urandom_range(26, 255);
			1: len = $urandom_range(20, 25);
			default: len = $urandom_range(26, 30);
		endcase
		corrupt = ($urandom_range(4) == 0) ? int'($urandom_range(OFS_GRAV_LO)) : -1;
		add_beacon(nib, len, pick16(), pick16(), corrupt);
	endtask

	task automatic random_ad();
		int unsigned r, cut;
		r = $urandom_range(99);
		repeat ($urandom_range(2)) add_filler();
		if ($urandom_range(99) < 8) ad_bytes.push_back(8'h00);
		if (r < 55) begin
			add_random_beacon();
		end else if (r < 75) begin
			repeat ($urandom_range(1, 6)) ad_bytes.push_back(8'($urandom_range(255)));
		end else begin
			add_filler();
		end
		// a second candidate after the first: only the first match counts
		if ($urandom_range(99) < 30) begin
			if ($urandom_range(1) != 0) add_random_beacon();
			else add_filler();
		end
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(1, ad_bytes.size());
			while (ad_bytes.size() > cut) ad_bytes.delete(ad_bytes.size() - 1);
		end
		send_ad($urandom_range(99) < 5);
	endtask

	// write the filter register, then read it back
	task automatic write_colour_filter(input logic [3:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_COLOUR_FILTER;
		pwdata <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		filter_cfg = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {28'd0, v}) begin
			$display("%0t: colour_filter readback, expected %0h, actual %0h",
				$time, {28'd0, v}, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// idle until every item is taken and every result is in, plus pipeline slack
	task automatic wait_drained();
		while (pending_items.size() != 0 || adv_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [3:0]  phase_filter [6];
		int unsigned items0, results0;
		phase_filter[0] = 4'd8;
		phase_filter[1] = 4'd0;
		phase_filter[2] = 4'd15;
		phase_filter[3] = 4'd3;
		phase_filter[4] = 4'd9;
		phase_filter[5] = 4'($urandom_range(8));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: length byte as last byte
		ad_bytes.push_back(8'h1A);
		send_ad(1'b0);
		// zero length stops the parse
		ad_bytes.push_back(8'h00);
		ad_bytes.push_back(8'hFF);
		send_ad(1'b0);
		// structure overruns the payload
		ad_bytes.push_back(8'h1A);
		ad_bytes.push_back(8'hFF);
		ad_bytes.push_back(8'h4C);
		send_ad(1'b0);
		add_beacon(4'd8, MIN_BEACON_LEN, 16'hFFFF, 16'hFFFF, -1);
		send_ad(1'b0);
		add_beacon(4'd8, MIN_BEACON_LEN, 16'h0000, 16'h0000, -1);
		send_ad(1'b0);
		add_beacon(4'd1, MIN_BEACON_LEN + 1, 16'h0000, 16'h0000, -1);
		send_ad(1'b0);
		// colour nibble out of range
		add_beacon(4'd0, MIN_BEACON_LEN, 16'h1234, 16'h5678, -1);
		send_ad(1'b0);
		push_scan();
		push_scan();
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 13;
				recv_idle_pct = 65;
			end else if (ph < 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_colour_filter(phase_filter[ph]);
			items0 = gen_items;
			results0 = gen_results;
			while (gen_items - items0 < 170 || gen_results - results0 < 12) begin
				random_ad();
				if ($urandom_range(99) < 12) push_scan();
			end
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
